/* src/lcs_pkg.sv */
package lcs_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD_OLD = 2'd0,
      CMD_LOAD_NEW = 2'd1,
      CMD_RUN      = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_DEL  = 2'd1,
      OP_SAME = 2'd2,
      OP_RSVD = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_RD,
      ST_ROW_SWEEP,
      ST_BT_RD,
      ST_BT_WAIT,
      ST_BT_STEP,
      ST_DONE
   } state_type;

   localparam int OP_BITS  = 2;
   localparam int POS_BITS = 6;
   localparam int SRC_BITS = 5;

endpackage

/* src/lcs_ram.sv */
module lcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* src/lcs_cell.sv */
// One column of the LCS row. Each cell holds its new-line token and its table value
// for the current row; the diagonal value ripples in from the left neighbor.
module lcs_cell #(
   parameter int TOKEN_BITS = 32,
   parameter int VAL_BITS   = 6
) (
   input  logic                  clock,
   input  logic                  tok_we,
   input  logic [TOKEN_BITS-1:0] tok_in,
   input  logic                  clr,
   input  logic                  upd,
   input  logic [TOKEN_BITS-1:0] old_tok,
   input  logic [VAL_BITS-1:0]   left_val,
   input  logic [VAL_BITS-1:0]   diag_val,
   output logic [VAL_BITS-1:0]   val
);

   logic [TOKEN_BITS-1:0] tok_ff;
   logic [VAL_BITS-1:0]   val_ff, val_in;
   logic                  match;

   assign match = (tok_ff == old_tok);
   assign val   = val_ff;

   always_comb begin
      if (match) begin
         val_in = diag_val + VAL_BITS'(1);
      end else if (val_ff > left_val) begin
         val_in = val_ff;
      end else begin
         val_in = left_val;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_we) begin
         tok_ff <= tok_in;
      end
      if (clr) begin
         val_ff <= '0;
      end else if (upd) begin
         val_ff <= val_in;
      end
   end

endmodule

/* src/lcs_line_diff_engine_unit.sv */
// Loads leave busy low, so a new command can follow in the next cycle. A run of n old
// and m new lines fills the table one row per sweep through the chain of column cells,
// then walks back through the read, wait and step states for each move until it reaches
// the origin, and finishes. Each edit leaves as the next one is found; the last one
// appears in the same cycle that busy falls. The receiver cannot stall the result strobe.
// Reset (synchronous, active high) clears both line counts and the controller.
module lcs_line_diff_engine_unit #(
   parameter int MAX_LINES  = 32,
   parameter int TOKEN_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_line_token,
   output logic        rsp_valid,
   output logic [1:0]  rsp_op_kind,
   output logic [5:0]  rsp_position,
   output logic [4:0]  rsp_source_line,
   output logic        rsp_last_op
);
   import lcs_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_LINES + 1);
   localparam int IDX_BITS = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int VAL_BITS = CNT_BITS;
   localparam int DIM      = MAX_LINES + 1;
   localparam int TBL_DEPTH = DIM * DIM;
   localparam int TA_BITS  = $clog2(TBL_DEPTH);

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] old_len_ff, new_len_ff;
   logic [CNT_BITS-1:0] i_ff, i_in, j_ff, j_in, col_ff, col_in;
   // Set once the backtrack has found an edit; the pending registers then hold it.
   logic                any_ff, any_in;
   logic [TOKEN_BITS-1:0] tok;

   // An edit is held until the next one is found or the walk ends, so that the final
   // one can carry last; the result registers then hold it for output.
   op_type              pend_kind_ff, pend_kind_in;
   logic [POS_BITS-1:0] pend_pos_ff, pend_pos_in;
   logic [SRC_BITS-1:0] pend_src_ff, pend_src_in;
   logic           out_v_ff, out_v_in, out_last_ff, out_last_in;
   op_type         out_kind_ff, out_kind_in;
   logic [POS_BITS-1:0] out_pos_ff, out_pos_in;
   logic [SRC_BITS-1:0] out_src_ff, out_src_in;

   assign tok = TOKEN_BITS'(req_line_token);
   wire accept = start && !busy;
   wire cmd_old = accept && cmd_type'(req_command) == CMD_LOAD_OLD &&
                  old_len_ff < CNT_BITS'(MAX_LINES);
   wire cmd_new = accept && cmd_type'(req_command) == CMD_LOAD_NEW &&
                  new_len_ff < CNT_BITS'(MAX_LINES);

   // Old-line store, also read during backtrack for the match test.
   logic [IDX_BITS-1:0]   old_rd_addr;
   logic [TOKEN_BITS-1:0] old_rd;
   lcs_ram #(.WIDTH(TOKEN_BITS), .DEPTH(MAX_LINES)) u_old (
      .clock(clock), .wr_en(cmd_old), .wr_addr(old_len_ff[IDX_BITS-1:0]),
      .wr_data(tok), .rd_addr(old_rd_addr), .rd_data(old_rd));

   // Chain of column cells.
   logic [VAL_BITS-1:0] vals [MAX_LINES];
   logic [VAL_BITS-1:0] diag_ff [MAX_LINES];
   logic cells_clr, cells_upd;

   // Within a sweep, cell c updates when col_ff == c+1; left neighbor already holds
   // the new row value, diag_ff holds that neighbor's previous-row value.
   for (genvar c = 0; c < MAX_LINES; c++) begin : g_col
      logic [VAL_BITS-1:0] left;
      if (c == 0) begin : g_first
         assign left = '0;
      end else begin : g_rest
         assign left = vals[c-1];
      end
      lcs_cell #(.TOKEN_BITS(TOKEN_BITS), .VAL_BITS(VAL_BITS)) u_cell (
         .clock(clock),
         .tok_we(cmd_new && new_len_ff[IDX_BITS-1:0] == IDX_BITS'(c)),
         .tok_in(tok), .clr(cells_clr),
         .upd(cells_upd && col_ff == CNT_BITS'(c + 1)),
         .old_tok(old_rd), .left_val(left), .diag_val(diag_ff[c]),
         .val(vals[c]));
      always_ff @(posedge clock) begin
         if (cells_clr) begin
            diag_ff[c] <= '0;
         end else if (cells_upd && col_ff == CNT_BITS'(c)) begin
            diag_ff[c] <= left;
         end
      end
   end

   // Table memory: row i column j at i*DIM+j; row 0 and column 0 read as zero by control.
   logic                wr_en;
   logic [TA_BITS-1:0]  wr_addr, rd_addr;
   logic [VAL_BITS-1:0] wr_data, rd_data;
   logic [CNT_BITS-1:0] wcol, wcell;
   // The column written now belongs to the cell that updated on the previous edge.
   always_comb begin
      wcol = col_ff - CNT_BITS'(1);
      wcell = col_ff - CNT_BITS'(2);
      wr_data = vals[wcell[IDX_BITS-1:0]];
   end
   lcs_ram #(.WIDTH(VAL_BITS), .DEPTH(TBL_DEPTH)) u_tbl (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   // Backtrack reads left (i,j-1) then up (i-1,j).
   logic [VAL_BITS-1:0] left_ff, left_in;
   logic [TOKEN_BITS-1:0] newtok_ff;
   logic [TOKEN_BITS-1:0] new_rd;
   logic [CNT_BITS-1:0]  jm1;
   logic [CNT_BITS-1:0]  im1;

   // The new-line token for the backtrack match test is a second copy in a small RAM.
   lcs_ram #(.WIDTH(TOKEN_BITS), .DEPTH(MAX_LINES)) u_new (
      .clock(clock), .wr_en(cmd_new), .wr_addr(new_len_ff[IDX_BITS-1:0]),
      .wr_data(tok), .rd_addr(jm1[IDX_BITS-1:0]), .rd_data(new_rd));

   assign jm1 = j_ff - CNT_BITS'(1);
   assign im1 = i_ff - CNT_BITS'(1);
   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = out_v_ff;
   assign rsp_op_kind = out_kind_ff;
   assign rsp_position = out_pos_ff;
   assign rsp_source_line = out_src_ff;
   assign rsp_last_op = out_last_ff;

   function automatic logic [TA_BITS-1:0] taddr(logic [CNT_BITS-1:0] r,
                                               logic [CNT_BITS-1:0] c);
      taddr = TA_BITS'(r * DIM + c);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         old_len_ff <= '0;
         new_len_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         if (cmd_old) old_len_ff <= old_len_ff + CNT_BITS'(1);
         if (cmd_new) new_len_ff <= new_len_ff + CNT_BITS'(1);
         if (state_ff == ST_DONE) begin
            old_len_ff <= '0;
            new_len_ff <= '0;
         end
      end
      i_ff <= i_in;
      j_ff <= j_in;
      col_ff <= col_in;
      any_ff <= any_in;
      left_ff <= left_in;
      newtok_ff <= new_rd;
      pend_kind_ff <= pend_kind_in;
      pend_pos_ff <= pend_pos_in;
      pend_src_ff <= pend_src_in;
      out_kind_ff <= out_kind_in;
      out_pos_ff <= out_pos_in;
      out_src_ff <= out_src_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      logic tok_eq, go_add;
      state_in = state_ff;
      i_in = i_ff; j_in = j_ff; col_in = col_ff; any_in = any_ff;
      left_in = left_ff;
      pend_kind_in = pend_kind_ff; pend_pos_in = pend_pos_ff; pend_src_in = pend_src_ff;
      out_v_in = 1'b0; out_kind_in = out_kind_ff; out_pos_in = out_pos_ff;
      out_src_in = out_src_ff; out_last_in = 1'b0;
      cells_clr = 1'b0; cells_upd = 1'b0;
      wr_en = 1'b0; wr_addr = taddr(i_ff, col_ff); rd_addr = taddr(i_ff, jm1);
      old_rd_addr = im1[IDX_BITS-1:0];
      tok_eq = (old_rd == newtok_ff);
      go_add = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && cmd_type'(req_command) == CMD_RUN) begin
               cells_clr = 1'b1;
               i_in = CNT_BITS'(1);
               any_in = 1'b0;
               state_in = (old_len_ff == '0) ? ST_BT_RD : ST_ROW_RD;
               if (old_len_ff == '0) i_in = '0;
               j_in = new_len_ff;
            end
         end
         ST_ROW_RD: begin
            // Fetch old token i-1; cells see it next cycle.
            col_in = '0;
            state_in = ST_ROW_SWEEP;
         end
         ST_ROW_SWEEP: begin
            cells_upd = 1'b1;
            wr_en = (col_ff >= CNT_BITS'(2));
            wr_addr = taddr(i_ff, wcol);
            if (col_ff == new_len_ff + CNT_BITS'(1)) begin
               if (i_ff == old_len_ff) begin
                  state_in = ST_BT_RD;
               end else begin
                  i_in = i_ff + CNT_BITS'(1);
                  state_in = ST_ROW_RD;
               end
            end else begin
               col_in = col_ff + CNT_BITS'(1);
            end
         end
         ST_BT_RD: begin
            // Issue reads: old token i-1, new token j-1, table (i,j-1).
            rd_addr = taddr(i_ff, jm1);
            state_in = ST_BT_WAIT;
         end
         ST_BT_WAIT: begin
            left_in = (i_ff == 0 || j_ff <= CNT_BITS'(1)) ? '0 : rd_data;
            rd_addr = taddr(im1, j_ff);
            state_in = ST_BT_STEP;
         end
         ST_BT_STEP: begin
            if (i_ff == 0 && j_ff == 0) begin
               state_in = ST_DONE;
            end else begin
               if (i_ff != 0 && j_ff != 0 && tok_eq) begin
                  i_in = im1; j_in = jm1;
               end else begin
                  go_add = (j_ff != 0) && (i_ff == 0 ||
                           left_ff >= ((im1 == 0) ? VAL_BITS'(0) : rd_data));
                  // A new edit follows, so the pending one is not the last.
                  out_v_in = any_ff;
                  out_kind_in = pend_kind_ff;
                  out_pos_in = pend_pos_ff;
                  out_src_in = pend_src_ff;
                  any_in = 1'b1;
                  pend_kind_in = go_add ? OP_ADD : OP_DEL;
                  pend_pos_in = POS_BITS'(go_add ? i_ff : im1);
                  pend_src_in = go_add ? SRC_BITS'(jm1) : '0;
                  if (go_add) j_in = jm1; else i_in = im1;
               end
               state_in = ST_BT_RD;
            end
         end
         ST_DONE: begin
            out_v_in = 1'b1;
            out_last_in = 1'b1;
            if (any_ff) begin
               out_kind_in = pend_kind_ff;
               out_pos_in = pend_pos_ff;
               out_src_in = pend_src_ff;
            end else begin
               out_kind_in = OP_SAME;
               out_pos_in = '0;
               out_src_in = '0;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* tb/sv/lcs_diff_checker.sv */
// Watches command transfers into the diff engine, computes the edit script that each run
// command must produce and compares every result transfer with the oldest pending entry.
module lcs_diff_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_line_token,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_op_kind,
   input  logic [5:0]  rsp_position,
   input  logic [4:0]  rsp_source_line,
   input  logic        rsp_last_op,
   output int          fail_count,
   output int          pending_ops,
   output int          ops_seen
);
   import lcs_pkg::*;

   typedef struct packed {
      op_type     kind;
      logic [5:0] pos;
      logic [4:0] src;
      logic       last;
   } edit_op_type;

   logic [31:0] base_tok [32];
   logic [31:0] edit_tok [32];
   int          base_num;
   int          edit_num;
   edit_op_type script_q [$];

   assign pending_ops = script_q.size();

   // Fills the LCS lengths and backtracks from the end; ties go to the add.
   task automatic build_script();
      int          lcs [33][33];
      int          i;
      int          j;
      int          emitted;
      edit_op_type op;
      emitted = 0;
      for (i = 0; i <= base_num; i++) begin
         for (j = 0; j <= edit_num; j++) begin
            if (i == 0 || j == 0) lcs[i][j] = 0;
            else if (base_tok[i-1] == edit_tok[j-1]) lcs[i][j] = lcs[i-1][j-1] + 1;
            else lcs[i][j] = (lcs[i-1][j] > lcs[i][j-1]) ? lcs[i-1][j] : lcs[i][j-1];
         end
      end
      i = base_num;
      j = edit_num;
      while (i > 0 || j > 0) begin
         if (i > 0 && j > 0 && base_tok[i-1] == edit_tok[j-1]) begin
            i--;
            j--;
         end else if (j > 0 && (i == 0 || lcs[i][j-1] >= lcs[i-1][j])) begin
            op = '{kind: OP_ADD, pos: 6'(i), src: 5'(j - 1), last: 1'b0};
            script_q.push_back(op);
            emitted++;
            j--;
         end else begin
            op = '{kind: OP_DEL, pos: 6'(i - 1), src: 5'd0, last: 1'b0};
            script_q.push_back(op);
            emitted++;
            i--;
         end
      end
      if (emitted == 0) begin
         op = '{kind: OP_SAME, pos: 6'd0, src: 5'd0, last: 1'b0};
         script_q.push_back(op);
      end
      script_q[script_q.size() - 1].last = 1'b1;
      base_num = 0;
      edit_num = 0;
   endtask

   always @(posedge clock) begin
      edit_op_type want;
      if (reset) begin
         base_num = 0;
         edit_num = 0;
         fail_count <= 0;
         ops_seen   <= 0;
         script_q.delete();
      end else begin
         if (rsp_valid) begin
            ops_seen <= ops_seen + 1;
            if (script_q.size() == 0) begin
               $display("%0t: unexpected result kind=%0d pos=%0d src=%0d last=%0b", $time,
                        rsp_op_kind, rsp_position, rsp_source_line, rsp_last_op);
               fail_count <= fail_count + 1;
            end else begin
               want = script_q.pop_front();
               if (rsp_op_kind !== want.kind || rsp_position !== want.pos ||
                   rsp_source_line !== want.src || rsp_last_op !== want.last) begin
                  $display("%0t: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                           $time, want.kind, want.pos, want.src, want.last,
                           rsp_op_kind, rsp_position, rsp_source_line, rsp_last_op);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) begin
            case (cmd_type'(req_command))
               CMD_LOAD_OLD: if (base_num < 32) begin
                  base_tok[base_num] = req_line_token;
                  base_num = base_num + 1;
               end
               CMD_LOAD_NEW: if (edit_num < 32) begin
                  edit_tok[edit_num] = req_line_token;
                  edit_num = edit_num + 1;
               end
               CMD_RUN: build_script();
               default: ;
            endcase
         end
      end
   end

endmodule

/* tb/sv/tb_top.sv */
// Stimulus and verdict for the line diff engine. The checker beside the block predicts
// and compares; this module only produces command transfers and decides the outcome.
module tb_top;
   import lcs_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_command;
   logic [31:0] req_line_token;
   logic        rsp_valid;
   logic [1:0]  rsp_op_kind;
   logic [5:0]  rsp_position;
   logic [4:0]  rsp_source_line;
   logic        rsp_last_op;
   int          fail_count;
   int          pending_ops;
   int          ops_seen;
   int          items_sent;
   int          runs_sent;
   int          idle_cycles;

   // A quiet spell longer than this means the block has hung. The slowest run fills
   // 32 rows and backtracks 64 steps, well under this limit.
   localparam int HANG_LIMIT = 20000;

   lcs_line_diff_engine_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_line_token(req_line_token),
      .rsp_valid(rsp_valid), .rsp_op_kind(rsp_op_kind), .rsp_position(rsp_position),
      .rsp_source_line(rsp_source_line), .rsp_last_op(rsp_last_op)
   );

   lcs_diff_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_line_token(req_line_token),
      .rsp_valid(rsp_valid), .rsp_op_kind(rsp_op_kind), .rsp_position(rsp_position),
      .rsp_source_line(rsp_source_line), .rsp_last_op(rsp_last_op),
      .fail_count(fail_count), .pending_ops(pending_ops), .ops_seen(ops_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The watchdog counts cycles in which neither a command nor a result is transferred.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= HANG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   // Sends one command and holds it until the block takes it. After a transfer, start
   // falls only when a gap follows; a back-to-back command keeps start high.
   task automatic send_cmd(input cmd_type cmd, input logic [31:0] token, input int gap);
      start          <= 1'b1;
      req_command    <= cmd;
      req_line_token <= token;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (cmd == CMD_RUN) runs_sent++;
      if (gap > 0) begin
         start          <= 1'b0;
         req_command    <= 2'($urandom);
         req_line_token <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Burst pacing: a run of back-to-back transfers, then a random gap.
   int burst_left;
   function automatic int next_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      burst_left = $urandom_range(0, 8);
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
   endfunction

   // Draws tokens from a small alphabet so that lines match often; a few are fully random.
   function automatic logic [31:0] pick_token(input int alphabet);
      if ($urandom_range(0, 15) == 0) return $urandom;
      return 32'($urandom_range(0, alphabet - 1)) ^ 32'hA5A5_0000;
   endfunction

   // Loads two lists and runs the diff. Sizes are mostly small; new lines are often an
   // edited copy of the old ones so the scripts hold a mix of adds and deletes.
   task automatic random_diff(input int n_old, input int n_new, input int alphabet);
      logic [31:0] olds [40];
      int          k;
      for (k = 0; k < n_old; k++) begin
         olds[k] = pick_token(alphabet);
         send_cmd(CMD_LOAD_OLD, olds[k], next_gap());
      end
      for (k = 0; k < n_new; k++) begin
         if (k < n_old && $urandom_range(0, 2) != 0)
            send_cmd(CMD_LOAD_NEW, olds[k], next_gap());
         else
            send_cmd(CMD_LOAD_NEW, pick_token(alphabet), next_gap());
         if ($urandom_range(0, 40) == 0) send_cmd(CMD_NONE, $urandom, next_gap());
      end
      send_cmd(CMD_RUN, $urandom, next_gap());
   endtask

   initial begin
      int k;
      start          <= 1'b0;
      req_command    <= CMD_NONE;
      req_line_token <= '0;
      reset          <= 1'b1;
      items_sent  = 0;
      runs_sent   = 0;
      burst_left  = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty run, equal lists, token extremes, an unknown command, a pure add,
      // a pure delete, and a load past the 32-line capacity on the old side.
      send_cmd(CMD_RUN, 32'h0, 0);
      send_cmd(CMD_LOAD_OLD, 32'hFFFF_FFFF, 0);
      send_cmd(CMD_LOAD_NEW, 32'hFFFF_FFFF, 0);
      send_cmd(CMD_NONE, 32'h5555_AAAA, 1);
      send_cmd(CMD_RUN, 32'hFFFF_FFFF, 0);
      send_cmd(CMD_LOAD_NEW, 32'h0000_0000, 0);
      send_cmd(CMD_RUN, 32'h0, 2);
      send_cmd(CMD_LOAD_OLD, 32'h8000_0000, 0);
      send_cmd(CMD_LOAD_OLD, 32'h0000_0001, 0);
      send_cmd(CMD_RUN, 32'h0, 0);
      send_cmd(CMD_LOAD_OLD, 32'h1234_5678, 0);
      send_cmd(CMD_LOAD_NEW, 32'h8765_4321, 0);
      send_cmd(CMD_RUN, 32'h0, 0);
      for (k = 0; k < 34; k++) send_cmd(CMD_LOAD_OLD, 32'(k), 0);
      send_cmd(CMD_RUN, 32'h0, 3);

      // Random: mostly short lists, a few at the full 32 lines on both sides.
      while (items_sent < 470) begin
         if ($urandom_range(0, 24) == 0)
            random_diff(32 + $urandom_range(0, 2), 32 + $urandom_range(0, 2), 6);
         else
            random_diff($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(1, 5));
      end

      start <= 1'b0;
      @(posedge clock);
      while (busy || pending_ops != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("tb_top: %0d commands sent, %0d diff runs, %0d edit results checked",
               items_sent, runs_sent, ops_seen);
      if (fail_count == 0 && pending_ops == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
